// ===== src/mrdh_pkg.sv =====
// Shared constants, types and helpers for the multiply-rotate digest hash.
`default_nettype none

package mrdh_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDE_WORDS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DIGEST_LOG2 = CFG_IDX_W'(1);

	localparam logic                  RESET_WIDE = 1'b1;
	localparam logic [CFG_DATA_W-1:0] RESET_LOG2 = 3'd4;
	localparam logic [CFG_DATA_W-1:0] LOG2_MIN   = 3'd2;
	localparam logic [CFG_DATA_W-1:0] LOG2_MAX   = 3'd5;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_DIGEST_WORDS = 32;
	localparam int DEF_WARMUP_STEPS     = 16;

	// Control from the sequencer to the generator unit.
	typedef struct packed {
		logic clear;
		logic start;
		logic wide;
	} gen_ctl_t;

	// Status from the generator unit back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} gen_sts_t;

	// Keeps a word to 32 bits in narrow mode.
	function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
			input logic wide);
		mask_word = wide ? w : {{(WORD_W-HALF_W){1'b0}}, w[HALF_W-1:0]};
	endfunction

endpackage

`default_nettype wire

// ===== src/mrdh_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
`default_nettype none

interface mrdh_msg_if;
	import mrdh_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic              has_word;
	logic              last_word;

	modport source(output valid, data_word, has_word, last_word, input ready);
	modport sink(input valid, data_word, has_word, last_word, output ready);
endinterface

interface mrdh_digest_if;
	import mrdh_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic              digest_last;

	modport source(output valid, digest_word, digest_last, input ready);
	modport sink(input valid, digest_word, digest_last, output ready);
endinterface

`default_nettype wire

// ===== src/multiply_rotate_digest_hash.sv =====
// Top level of the multiply-rotate digest hash: sequencer, digest store and channels.
//
// Message words arrive as beats on the msg channel (data_word, has_word, last_word)
// and digest words leave as beats on the digest channel, index zero first, with
// digest_last set on the final word. Configuration is written through cfg_we,
// cfg_idx and cfg_wdata: index 0 selects 32- or 64-bit words, index 1 sets the
// log2 of the digest size. A write to either aborts the message and starts over.
//
// Each beat that carries a word runs one generator step on a shared 32x32
// multiplier, which takes three partial products in 64-bit mode and one in 32-bit
// mode; the block takes no new beat until that step is done. A closing beat then
// runs one generator step per digest word and reads the digest out word by word,
// through a read state and a load state for each.
// After reset, after every digest and after every write to index 0 or 1, the block
// clears its generator words and digest store and runs the warm-up steps, and
// msg.ready stays low meanwhile. Reset is asynchronous and active low.
// The digest word sits in an output register; when the receiver stalls, the block
// holds that beat and waits before reading the next word, and it goes on with the
// warm-up while the last beat of a digest is still waiting to be taken.
`default_nettype none

module multiply_rotate_digest_hash #(
	parameter int MAX_DIGEST_WORDS = mrdh_pkg::DEF_MAX_DIGEST_WORDS,
	parameter int WARMUP_STEPS     = mrdh_pkg::DEF_WARMUP_STEPS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	mrdh_msg_if.sink                             msg,
	mrdh_digest_if.source                        digest,
	input  wire logic                            cfg_we,
	input  wire logic [mrdh_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [mrdh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mrdh_pkg::*;

	localparam int AW     = (MAX_DIGEST_WORDS > 1) ? $clog2(MAX_DIGEST_WORDS) : 1;
	localparam int MAX_LG = $clog2(MAX_DIGEST_WORDS + 1) - 1;
	localparam int WCW    = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;

	localparam logic [3:0] S_INIT      = 4'd0;
	localparam logic [3:0] S_WARM      = 4'd1;
	localparam logic [3:0] S_WARM_WAIT = 4'd2;
	localparam logic [3:0] S_IDLE      = 4'd3;
	localparam logic [3:0] S_DATA_WAIT = 4'd4;
	localparam logic [3:0] S_FIN_GO    = 4'd5;
	localparam logic [3:0] S_FIN_WAIT  = 4'd6;
	localparam logic [3:0] S_OUT_RD    = 4'd7;
	localparam logic [3:0] S_OUT_LD    = 4'd8;

	logic [3:0]                  state_q;
	logic                        wide_q;
	logic [CFG_DATA_W-1:0]       log2_q;
	logic [AW-1:0]               wp_q, k_q;
	logic [WCW-1:0]              warm_cnt_q;
	logic [MAX_DIGEST_WORDS-1:0] valid_q;
	logic [WORD_W-1:0]           xacc_q, x_q;
	logic                        last_q;
	logic                        out_valid_q, out_last_q;
	logic [WORD_W-1:0]           out_word_q;

	logic [CFG_DATA_W-1:0] lg_eff;
	logic [AW-1:0]         size_mask, idx, rd_addr;
	logic                  cfg_hit, msg_acc, out_load, k_last;
	logic [WORD_W-1:0]     ram_rdata, rd_word, new_word, gen_v, gen_res;
	logic                  ram_we;
	gen_ctl_t              gen_ctl;
	gen_sts_t              gen_sts;

	// The digest size follows digest_log2, held to 2..5 and to the store depth.
	always_comb begin
		lg_eff = log2_q;
		if (lg_eff < LOG2_MIN) begin
			lg_eff = LOG2_MIN;
		end
		if (lg_eff > LOG2_MAX) begin
			lg_eff = LOG2_MAX;
		end
		if (lg_eff > CFG_DATA_W'(MAX_LG)) begin
			lg_eff = CFG_DATA_W'(MAX_LG);
		end
	end

	assign size_mask = AW'((6'd1 << lg_eff) - 6'd1);
	assign idx       = (wp_q + k_q) & size_mask;
	assign k_last    = (k_q == size_mask);

	assign cfg_hit = cfg_we && (cfg_idx == REG_WIDE_WORDS || cfg_idx == REG_DIGEST_LOG2);
	assign msg.ready = (state_q == S_IDLE);
	assign msg_acc   = msg.valid && msg.ready;

	// The store is read where the current phase needs it; writes go to the same entry.
	always_comb begin
		if (state_q inside {S_FIN_GO, S_FIN_WAIT}) begin
			rd_addr = idx;
		end else if (state_q inside {S_OUT_RD, S_OUT_LD}) begin
			rd_addr = k_q;
		end else begin
			rd_addr = wp_q;
		end
	end

	// An entry not written since the last restart reads as zero.
	assign rd_word  = valid_q[rd_addr] ? ram_rdata : '0;
	assign new_word = rd_word ^ gen_res;
	assign ram_we   = gen_sts.done && (state_q == S_DATA_WAIT || state_q == S_FIN_WAIT);

	always_comb begin
		gen_ctl.clear = (state_q == S_INIT);
		gen_ctl.wide  = wide_q;
		gen_ctl.start = (state_q == S_WARM && warm_cnt_q != WCW'(WARMUP_STEPS))
			|| (msg_acc && msg.has_word)
			|| (state_q == S_FIN_GO);
		if (state_q == S_IDLE) begin
			gen_v = mask_word(msg.data_word, wide_q);
		end else if (state_q == S_FIN_GO) begin
			gen_v = x_q;
		end else begin
			gen_v = '0;
		end
	end

	mrdh_gen_unit u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gen_ctl),
		.v      (gen_v),
		.sts    (gen_sts),
		.result (gen_res)
	);

	mrdh_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_DIGEST_WORDS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_addr),
		.wdata (new_word),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign out_load = (state_q == S_OUT_LD) && (!out_valid_q || digest.ready);

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.digest_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			wide_q      <= RESET_WIDE;
			log2_q      <= RESET_LOG2;
			wp_q        <= '0;
			k_q         <= '0;
			warm_cnt_q  <= '0;
			valid_q     <= '0;
			xacc_q      <= '0;
			x_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				case (cfg_idx)
					REG_WIDE_WORDS: begin
						wide_q <= cfg_wdata[0];
					end
					REG_DIGEST_LOG2: begin
						log2_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						valid_q    <= '0;
						wp_q       <= '0;
						k_q        <= '0;
						xacc_q     <= '0;
						warm_cnt_q <= '0;
						state_q    <= S_WARM;
					end
					S_WARM: begin
						if (warm_cnt_q == WCW'(WARMUP_STEPS)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_WARM_WAIT;
						end
					end
					S_WARM_WAIT: begin
						if (gen_sts.done) begin
							warm_cnt_q <= warm_cnt_q + WCW'(1);
							state_q    <= S_WARM;
						end
					end
					S_IDLE: begin
						if (msg_acc) begin
							last_q <= msg.last_word;
							k_q    <= '0;
							x_q    <= xacc_q;
							if (msg.has_word) begin
								state_q <= S_DATA_WAIT;
							end else if (msg.last_word) begin
								state_q <= S_FIN_GO;
							end
						end
					end
					S_DATA_WAIT: begin
						if (gen_sts.done) begin
							// The running XOR tracks the XOR of all digest words.
							valid_q[wp_q] <= 1'b1;
							xacc_q        <= xacc_q ^ gen_res;
							x_q           <= xacc_q ^ gen_res;
							wp_q          <= (wp_q + AW'(1)) & size_mask;
							state_q       <= last_q ? S_FIN_GO : S_IDLE;
						end
					end
					S_FIN_GO: begin
						state_q <= S_FIN_WAIT;
					end
					S_FIN_WAIT: begin
						if (gen_sts.done) begin
							valid_q[idx] <= 1'b1;
							x_q          <= x_q ^ new_word;
							if (k_last) begin
								k_q     <= '0;
								state_q <= S_OUT_RD;
							end else begin
								k_q     <= k_q + AW'(1);
								state_q <= S_FIN_GO;
							end
						end
					end
					S_OUT_RD: begin
						state_q <= S_OUT_LD;
					end
					S_OUT_LD: begin
						if (out_load) begin
							if (k_last) begin
								state_q <= S_INIT;
							end else begin
								k_q     <= k_q + AW'(1);
								state_q <= S_OUT_RD;
							end
						end
					end
					default: begin
						state_q <= S_INIT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= rd_word;
			out_last_q <= k_last;
		end
	end

`ifndef SYNTH
	// The message channel only opens when no generator step is in flight.
	a_ready_gen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !gen_sts.busy)
		else $error("message channel ready while a generator step runs");

	// The write pointer stays inside the configured digest size.
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_INIT) |-> ((wp_q & ~size_mask) == '0))
		else $error("write pointer beyond digest size");

	// A finished step shows only while the sequencer waits for one or is in S_INIT.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		gen_sts.done |-> (state_q == S_WARM_WAIT || state_q == S_DATA_WAIT
			|| state_q == S_FIN_WAIT || state_q == S_INIT))
		else $error("generator step finished outside a wait state");
`endif

endmodule

`default_nettype wire

// ===== src/mrdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mrdh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// ===== src/mrdh_gen_unit.sv =====
// Generator unit: four generator words and one shared 32x32 multiplier.
`default_nettype none

module mrdh_gen_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mrdh_pkg::gen_ctl_t          ctl,
	input  wire logic [mrdh_pkg::WORD_W-1:0] v,
	output mrdh_pkg::gen_sts_t               sts,
	output logic      [mrdh_pkg::WORD_W-1:0] result
);
	import mrdh_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LL   = 3'd1;
	localparam logic [2:0] PH_LH   = 3'd2;
	localparam logic [2:0] PH_HL   = 3'd3;
	localparam logic [2:0] PH_FIN  = 3'd4;

	logic [2:0]        ph_q;
	// r0 is the word at the current position, r1..r3 the ones behind it.
	logic [WORD_W-1:0] r0_q, r1_q, r2_q, r3_q;
	logic [WORD_W-1:0] v_q, prod_q;
	logic [HALF_W-1:0] op_a, op_b;
	logic [WORD_W-1:0] mul;
	logic [HALF_W-1:0] hi_sum;
	logic [HALF_W-1:0] p32, rot32;
	logic [4:0]        sh32;
	logic [5:0]        sh64;
	logic [WORD_W-1:0] rot64, rot_val, mixed;

	// The low 64 bits of the product come from three partial products in 64-bit mode; 32-bit mode uses the low one only.
	always_comb begin
		op_a = (ph_q == PH_HL) ? r0_q[WORD_W-1:HALF_W] : r0_q[HALF_W-1:0];
		op_b = (ph_q == PH_LH) ? r1_q[WORD_W-1:HALF_W] : r1_q[HALF_W-1:0];
	end

	assign mul    = WORD_W'(op_a) * WORD_W'(op_b);
	assign hi_sum = prod_q[WORD_W-1:HALF_W] + mul[HALF_W-1:0];

	always_comb begin
		p32   = prod_q[HALF_W-1:0];
		sh32  = r2_q[4:0];
		sh64  = r2_q[5:0];
		rot32 = (sh32 == 5'd0) ? p32 :
			((p32 >> sh32) | (p32 << (6'd32 - {1'b0, sh32})));
		rot64 = (sh64 == 6'd0) ? prod_q :
			((prod_q >> sh64) | (prod_q << (7'd64 - {1'b0, sh64})));
		rot_val = ctl.wide ? rot64 : {{(WORD_W-HALF_W){1'b0}}, rot32};
		mixed   = mask_word(~(rot_val ^ r3_q) ^ v_q, ctl.wide);
	end

	assign result   = mixed;
	assign sts.busy = (ph_q != PH_IDLE);
	assign sts.done = (ph_q == PH_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else if (ctl.clear) begin
			ph_q <= PH_IDLE;
			r0_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else if (ctl.start) begin
			ph_q <= PH_LL;
		end else begin
			case (ph_q)
				PH_LL: begin
					ph_q <= ctl.wide ? PH_LH : PH_FIN;
				end
				PH_LH: begin
					ph_q <= PH_HL;
				end
				PH_HL: begin
					ph_q <= PH_FIN;
				end
				PH_FIN: begin
					// The new word replaces the oldest one and becomes the next position.
					r0_q <= mixed;
					r1_q <= r0_q;
					r2_q <= r1_q;
					r3_q <= r2_q;
					ph_q <= PH_IDLE;
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= v;
		end
		if (ph_q == PH_LL) begin
			prod_q <= mul;
		end else if (ph_q == PH_LH || ph_q == PH_HL) begin
			prod_q[WORD_W-1:HALF_W] <= hi_sum;
		end
	end
endmodule

`default_nettype wire

// ===== verif/multiply_rotate_digest_hash_tb.sv =====
// Self-checking testbench for the multiply-rotate digest hash, with its own digest predictor.

// What is tested, and how:
// The test process sends message beats on the msg channel. Each beat is offered in
// bursts of random length with random gaps between them. When a beat is accepted,
// the test runs it through a predictor that is kept inside this module. The
// predictor holds its own generator words, position, digest store and write pointer.
// Every closing beat queues the digest words that it predicts.
// A checker compares every digest beat that the receiver takes against the oldest
// queued word, field by field. A beat that arrives with nothing queued, and any
// field that differs, is reported and counted.
// The receiver runs its own ready pattern: steady, coin-flip, sparse and periodic,
// each held for a random stretch. On request it also holds off for a long
// stretch, so that the output register and the input channel back up.
// Registers are written only once the block has drained and finished its warm-up.
// A write to a real register restarts the message in the predictor as well.
// A watchdog ends the run if neither channel moves a beat for too long.

module multiply_rotate_digest_hash_tb;
	import mrdh_pkg::*;

	localparam int MAX_WORDS = DEF_MAX_DIGEST_WORDS;
	localparam int WARMUP    = DEF_WARMUP_STEPS;
	localparam int GEN_WORDS = 4;

	// Indexes past the register list; writes to them must leave the block alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_DIGEST_LOG2 + CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

	// SETTLE_CYCLES covers the warm-up in 64-bit mode, the longer of the two, with margin.
	localparam int SETTLE_CYCLES    = 150;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int END_QUIET_CYCLES = 300;
	// The longest correct quiet stretch is a long hold or a run of register writes.
	// Each of those is well under this limit, so it leaves a wide margin.
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int TARGET_ITEMS     = 360;
	localparam int PHASE_ITEMS      = 40;

	// The first random phases walk through fixed settings that include every extreme.
	// After those, the settings are drawn at random.
	localparam int                FIXED_PHASES = 8;
	localparam logic [7:0]        PHASE_WIDE   = 8'b0101_1010;
	localparam logic [8*3-1:0]    PHASE_LOG2   = {3'd4, 3'd3, 3'd6, 3'd1, 3'd2, 3'd5, 3'd7, 3'd0};

	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} digest_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mrdh_msg_if    msg ();
	mrdh_digest_if digest ();

	multiply_rotate_digest_hash u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.digest    (digest),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: its own copy of the registers, the generator and the digest store.
	logic                  model_wide;
	logic [CFG_DATA_W-1:0] model_log2;
	logic [WORD_W-1:0]     mix_words [GEN_WORDS];
	int                    mix_pos;
	logic [WORD_W-1:0]     acc_words [MAX_WORDS];
	int                    acc_ptr;

	// Digest words that have been predicted and not yet seen, oldest first.
	digest_beat_t digest_due [$];

	int   mismatch_count = 0;
	int   digest_index   = 0;
	int   words_sent     = 0;
	int   burst_left     = 0;
	int   quiet_cycles   = 0;
	logic hold_req       = 1'b0;

	function automatic logic [WORD_W-1:0] word_mask();
		return model_wide ? {WORD_W{1'b1}} : {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
	endfunction

	// Number of digest words. Out-of-range sizes are clamped into the legal span, and
	// the size is then kept within the store.
	function automatic int digest_size();
		int lg;
		lg = model_log2;
		if (lg < LOG2_MIN) lg = LOG2_MIN;
		if (lg > LOG2_MAX) lg = LOG2_MAX;
		while (lg > LOG2_MIN && (1 << lg) > MAX_WORDS) lg--;
		return 1 << lg;
	endfunction

	// One generator step at position pos, mixing in v. The step's output replaces the
	// word three places back, which is the oldest of the four.
	function automatic logic [WORD_W-1:0] mix_step(input int pos, input logic [WORD_W-1:0] v);
		int a, b, c, d, bits, rot;
		logic [WORD_W-1:0] m, prod, x;
		m    = word_mask();
		bits = model_wide ? WORD_W : HALF_W;
		a    = pos % GEN_WORDS;
		b    = (a + GEN_WORDS - 1) % GEN_WORDS;
		c    = (b + GEN_WORDS - 1) % GEN_WORDS;
		d    = (c + GEN_WORDS - 1) % GEN_WORDS;
		prod = (mix_words[a] * mix_words[b]) & m;
		rot  = int'(mix_words[c][5:0]) & (bits - 1);
		x    = prod;
		// A rotate by zero leaves the product as it is.
		if (rot != 0) x = ((prod >> rot) | (prod << (bits - rot))) & m;
		x = (~(x ^ mix_words[d]) ^ v) & m;
		mix_words[d] = x;
		return x;
	endfunction

	// Clear the generator and the digest store, then warm up. This runs after reset,
	// after every digest and after every write to a real register.
	function automatic void restart_message();
		for (int k = 0; k < GEN_WORDS; k++) mix_words[k] = '0;
		for (int k = 0; k < MAX_WORDS; k++) acc_words[k] = '0;
		for (int k = 0; k < WARMUP; k++) void'(mix_step(k % GEN_WORDS, '0));
		mix_pos = WARMUP % GEN_WORDS;
		acc_ptr = 0;
	endfunction

	// Apply one accepted message beat and queue the digest words that it causes.
	function automatic void absorb_item(input logic [WORD_W-1:0] w, input logic has,
			input logic last);
		int size, idx, pos;
		logic [WORD_W-1:0] m, fold;
		digest_beat_t beat;
		size    = digest_size();
		m       = word_mask();
		acc_ptr = acc_ptr & (size - 1);
		if (has) begin
			acc_words[acc_ptr] ^= mix_step(mix_pos, w & m);
			mix_pos = (mix_pos + 1) % GEN_WORDS;
			acc_ptr = (acc_ptr + 1) & (size - 1);
		end
		if (!last) return;
		// Final pass. The fold starts as the XOR of the whole store. Each step then
		// feeds the fold into the next digest word from the write pointer onward.
		fold = '0;
		for (int k = 0; k < size; k++) fold ^= acc_words[k];
		pos = mix_pos;
		for (int k = 0; k < size; k++) begin
			idx = (acc_ptr + k) & (size - 1);
			acc_words[idx] ^= mix_step(pos, fold);
			fold ^= acc_words[idx];
			pos = (pos + 1) % GEN_WORDS;
		end
		for (int k = 0; k < size; k++) begin
			beat.word = acc_words[k] & m;
			beat.last = (k == size - 1);
			digest_due.push_back(beat);
		end
		restart_message();
	endfunction

	function automatic logic [WORD_W-1:0] pick_data_word();
		logic [WORD_W-1:0] one_hot;
		one_hot = 64'd1 << $urandom_range(0, WORD_W - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(input string field, input int index,
			input logic [WORD_W-1:0] want, input logic [WORD_W-1:0] got);
		// Printing stops after a while, but every mismatch is still counted.
		if (mismatch_count < 40)
			$display("[%0t] mismatch on %s, digest word %0d: expected %h, got %h",
				$time, field, index, want, got);
		mismatch_count++;
	endtask

	// Offer one beat and wait until it is taken. Valid stays high afterward, so a burst
	// runs on without a bubble. It drops when the burst ends and the gap begins, or on a drain.
	task automatic send_item(input logic [WORD_W-1:0] w, input logic has, input logic last);
		if (burst_left == 0) begin
			msg.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		msg.valid     <= 1'b1;
		msg.data_word <= w;
		msg.has_word  <= has;
		msg.last_word <= last;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
		absorb_item(w, has, last);
		if (has || last) words_sent++;
	endtask

	// Stop offering beats until every predicted digest word has been taken, then idle.
	// The drain is sampled on the falling edge, so it never races the checker.
	task automatic wait_drained(input int extra_cycles);
		msg.valid <= 1'b0;
		do @(negedge clk); while (digest_due.size() != 0);
		@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDE_WORDS) begin
			model_wide = value[0];
			restart_message();
		end else if (idx == REG_DIGEST_LOG2) begin
			model_log2 = value;
			restart_message();
		end
		// Let the warm-up that the write starts run to its end.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Extreme words, an idle beat, and then a closing beat with a word. An empty
	// closing beat follows and hashes a fresh state.
	task automatic test_default_digest();
		send_item(64'h0, 1'b1, 1'b0);
		send_item({WORD_W{1'b1}}, 1'b1, 1'b0);
		send_item(64'h8000_0000_0000_0001, 1'b1, 1'b0);
		send_item(64'h5555_5555_5555_5555, 1'b0, 1'b0);
		send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
		send_item(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1);
		send_item(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1);
		wait_drained(SETTLE_CYCLES);
	endtask

	// 32-bit words with the smallest digest. The upper halves carry junk that the
	// block must ignore, and six words wrap the write pointer.
	task automatic test_narrow_words();
		write_reg(REG_WIDE_WORDS, 3'b110);
		write_reg(REG_DIGEST_LOG2, LOG2_MIN);
		send_item(64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0);
		send_item({WORD_W{1'b1}}, 1'b1, 1'b0);
		send_item(64'h1234_5678_8000_0000, 1'b1, 1'b0);
		send_item(64'h0000_0000_0000_0001, 1'b1, 1'b0);
		send_item(64'hDEAD_BEEF_7FFF_FFFF, 1'b1, 1'b0);
		send_item(64'h0F0F_0F0F_F0F0_F0F0, 1'b1, 1'b1);
		wait_drained(SETTLE_CYCLES);
	endtask

	// Size codes below and above the legal span must clamp to the nearest legal size.
	task automatic test_digest_size_limits();
		write_reg(REG_WIDE_WORDS, 3'b001);
		write_reg(REG_DIGEST_LOG2, 3'd0);
		send_item(pick_data_word(), 1'b1, 1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_DIGEST_LOG2, 3'd7);
		send_item(pick_data_word(), 1'b0, 1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_DIGEST_LOG2, 3'd1);
		send_item(pick_data_word(), 1'b1, 1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_DIGEST_LOG2, 3'd6);
		send_item(pick_data_word(), 1'b0, 1'b1);
		wait_drained(SETTLE_CYCLES);
	endtask

	// A write past the register list leaves the message alone. A write to a real
	// register throws the words taken so far away.
	task automatic test_writes_mid_message();
		send_item(pick_data_word(), 1'b1, 1'b0);
		send_item(pick_data_word(), 1'b1, 1'b0);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_UNUSED_LAST, 3'b111);
		write_reg(REG_UNUSED_FIRST, 3'b010);
		send_item(pick_data_word(), 1'b1, 1'b1);
		wait_drained(SETTLE_CYCLES);
		send_item(pick_data_word(), 1'b1, 1'b0);
		send_item(pick_data_word(), 1'b1, 1'b0);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_DIGEST_LOG2, 3'd3);
		send_item(pick_data_word(), 1'b0, 1'b1);
		wait_drained(SETTLE_CYCLES);
	endtask

	// The receiver holds off for a long stretch while short messages keep coming. The
	// held digest beat stops the readout, and the input then backs up behind it.
	task automatic test_output_backpressure();
		write_reg(REG_WIDE_WORDS, 3'b001);
		write_reg(REG_DIGEST_LOG2, LOG2_MIN);
		hold_req <= 1'b1;
		for (int n = 0; n < 4; n++) begin
			send_item(pick_data_word(), 1'b1, 1'b0);
			send_item(pick_data_word(), 1'b1, 1'b0);
			send_item(pick_data_word(), 1'b1, 1'b1);
		end
		wait_drained(0);
	endtask

	// One message: most are short and a few are long enough to wrap the largest
	// digest. Idle beats are mixed in. An incomplete message is left hanging, and the
	// next register write drops it.
	task automatic send_random_message(input bit complete);
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) send_item(pick_data_word(), 1'b0, 1'b0);
			send_item(pick_data_word(), 1'b1, 1'b0);
		end
		if (complete) send_item(pick_data_word(), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic test_random_messages();
		int phase, quota_end;
		logic wide;
		logic [CFG_DATA_W-1:0] lg;
		phase = 0;
		while (words_sent < TARGET_ITEMS) begin
			wait_drained(SETTLE_CYCLES);
			if (phase < FIXED_PHASES) begin
				wide = PHASE_WIDE[phase];
				lg   = PHASE_LOG2[phase*3 +: 3];
			end else begin
				wide = 1'($urandom_range(0, 1));
				lg   = CFG_DATA_W'($urandom_range(0, 7));
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_DIGEST_LOG2, lg);
				write_reg(REG_WIDE_WORDS, {2'($urandom_range(0, 3)), wide});
			end else begin
				write_reg(REG_WIDE_WORDS, {2'($urandom_range(0, 3)), wide});
				write_reg(REG_DIGEST_LOG2, lg);
			end
			quota_end = words_sent + PHASE_ITEMS;
			while (words_sent < quota_end) send_random_message(1'b1);
			if ($urandom_range(0, 2) == 0) send_random_message(1'b0);
			phase++;
		end
	endtask

	// Receiver: a ready pattern of its own, with a long hold whenever the test asks.
	initial begin : receiver
		rx_mode_t rx_mode;
		int       mode_left;
		digest.ready <= 1'b0;
		rx_mode   = RX_STEADY;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req     <= 1'b0;
				digest.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
				RX_STEADY:  digest.ready <= 1'b1;
				RX_COIN:    digest.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:  digest.ready <= ($urandom_range(0, 3) == 0);
				default:    digest.ready <= (mode_left % 3 == 0);
			endcase
		end
	end

	// Every digest beat that is taken must match the oldest word still due.
	always @(posedge clk) begin : check_digest
		digest_beat_t due;
		if (arst_n && digest.valid && digest.ready) begin
			if (digest_due.size() == 0) begin
				report_mismatch("unexpected beat", digest_index, '0, digest.digest_word);
			end else begin
				due = digest_due.pop_front();
				if (digest.digest_word !== due.word)
					report_mismatch("digest_word", digest_index, due.word,
						digest.digest_word);
				if (digest.digest_last !== due.last)
					report_mismatch("digest_last", digest_index, WORD_W'(due.last),
						WORD_W'(digest.digest_last));
			end
			digest_index = digest.digest_last ? 0 : digest_index + 1;
		end
	end

	// The watchdog counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (msg.valid && msg.ready) || (digest.valid && digest.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_idx       <= '0;
		cfg_wdata     <= '0;
		msg.valid     <= 1'b0;
		msg.data_word <= '0;
		msg.has_word  <= 1'b0;
		msg.last_word <= 1'b0;
		model_wide = RESET_WIDE;
		model_log2 = RESET_LOG2;
		restart_message();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_default_digest();
		test_narrow_words();
		test_digest_size_limits();
		test_writes_mid_message();
		test_output_backpressure();
		test_random_messages();

		// Drain, then give the block time to show any stray beat it might still emit.
		wait_drained(END_QUIET_CYCLES);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
